FILE: src/cfr_pkg.sv
package cfr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MIN_LEN_W   = 7;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam int unsigned MAX_FRAME_LEN_DEF = 32;

  localparam logic [BYTE_W-1:0]    HEAD_RST    = 8'h42;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 7'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_HEAD = 2'd0,
    CFG_MIN_LEN    = 2'd1
  } cfr_cfg_e;

  typedef enum logic [1:0] {
    ST_RX,
    ST_SUM,
    ST_EM_RD,
    ST_EM_LD
  } cfr_state_t;

  typedef struct packed {
    logic rx_take;
    logic walk_clr;
    logic sum_run;
    logic em_read;
    logic em_load;
    logic set_link;
  } cfr_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic len_ok;
    logic chk_done;
    logic chk_good;
    logic out_free;
    logic em_last;
  } cfr_sts_t;

endpackage

FILE: src/cfr_in_if.sv
interface cfr_in_if import cfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/cfr_out_if.sv
interface cfr_out_if import cfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [POS_W-1:0]  byte_position;
  logic              last_byte;
  logic              link_up;

  modport source (output valid, output frame_byte, output byte_position,
                  output last_byte, output link_up, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input last_byte, input link_up, output ready);
endinterface

FILE: src/cfr_cfg_if.sv
interface cfr_cfg_if import cfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/cfr_ram.sv
module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/cfr_ctrl.sv
module cfr_ctrl import cfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cfr_sts_t sts,
  output cfr_cmd_t cmd
);

  cfr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RX: begin
        if (in_valid && sts.frame_end && sts.len_ok) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sts.chk_done) begin
          state_nxt = sts.chk_good ? ST_EM_RD : ST_RX;
        end
      end
      ST_EM_RD: state_nxt = ST_EM_LD;
      ST_EM_LD: begin
        if (sts.out_free) begin
          state_nxt = sts.em_last ? ST_RX : ST_EM_RD;
        end
      end
      default: state_nxt = ST_RX;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_RX: begin
        in_ready     = 1'b1;
        cmd.rx_take  = in_valid;
        cmd.walk_clr = 1'b1;
      end
      ST_SUM: begin
        cmd.sum_run  = 1'b1;
        cmd.walk_clr = sts.chk_done;
        cmd.set_link = sts.chk_done && sts.chk_good;
      end
      ST_EM_RD: cmd.em_read = 1'b1;
      ST_EM_LD: cmd.em_load = sts.out_free;
      default: ;
    endcase
  end

  ap_emit_only_after_good: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && state_nxt == ST_EM_RD) |-> cmd.set_link)
    else $error("emission started without a good checksum");

  ap_no_take_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RX) |-> !cmd.rx_take && !cmd.walk_clr || state_r == ST_SUM)
    else $error("input taken outside receive state");

  ap_load_leaves_ld: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.em_load && !sts.em_last) |=> state_r == ST_EM_RD)
    else $error("emission walk did not advance");

endmodule

FILE: src/cfr_dp.sv
module cfr_dp import cfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] rx_byte,
  cfr_cfg_if.sink           cfg,
  cfr_out_if.source         out_ch,
  input  cfr_cmd_t          cmd,
  output cfr_sts_t          sts
);

  localparam int unsigned AW = $clog2(MAX_FRAME_LEN);
  localparam int unsigned CW = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [BYTE_W-1:0] MAX_B = BYTE_W'(MAX_FRAME_LEN);

  logic [BYTE_W-1:0]    head_r;
  logic [MIN_LEN_W-1:0] min_r;
  logic                 recv_r, recv_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]    len_r, len_nxt;
  logic                 link_up_r;

  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [CW-1:0]        rd_idx_r;
  logic                 rd_vld_r;
  logic [BYTE_W-1:0]    sum_r, sum_nxt;

  logic                 out_vld_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [POS_W-1:0]     out_pos_r;
  logic                 out_last_r;
  logic                 out_link_r;

  logic                 recv_step, wr_en;
  logic [CW-1:0]        cnt_step;
  logic [AW-1:0]        wr_addr;
  logic [BYTE_W-1:0]    min_b;
  logic                 head_hit, frame_end;
  logic                 sum_issue, rd_en;
  logic [BYTE_W-1:0]    rd_data;

  assign min_b = BYTE_W'(min_r);

  // one receive step on the incoming byte
  always_comb begin
    head_hit  = (rx_byte == head_r) && !recv_r;
    recv_step = recv_r;
    cnt_step  = cnt_r;
    len_nxt   = len_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    if (head_hit) begin
      recv_step = 1'b1;
      cnt_step  = CW'(1);
      len_nxt   = min_b;
      wr_en     = 1'b1;
    end else if (cnt_r == CW'(2)) begin
      len_nxt  = rx_byte;
      cnt_step = CW'(3);
      wr_en    = 1'b1;
      wr_addr  = AW'(2);
      if (rx_byte > MAX_B || rx_byte < min_b) begin
        len_nxt   = min_b;
        cnt_step  = '0;
        recv_step = 1'b0;
      end
    end else if (recv_r && cnt_r < CW'(MAX_FRAME_LEN)) begin
      wr_en    = 1'b1;
      wr_addr  = cnt_r[AW-1:0];
      cnt_step = cnt_r + CW'(1);
    end
    frame_end = (BYTE_W'(cnt_step) >= MAX_B || BYTE_W'(cnt_step) >= len_nxt) &&
                BYTE_W'(cnt_step) > min_b;
    recv_nxt = frame_end ? 1'b0 : recv_step;
    cnt_nxt  = frame_end ? '0 : cnt_step;
  end

  assign sum_issue = cmd.sum_run && (BYTE_W'(ptr_r) < len_r);
  assign rd_en     = sum_issue || cmd.em_read;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.walk_clr) begin
      ptr_nxt = '0;
    end else if (sum_issue || cmd.em_load) begin
      ptr_nxt = ptr_r + CW'(1);
    end
    sum_nxt = sum_r;
    if (cmd.walk_clr) begin
      sum_nxt = '0;
    end else if (rd_vld_r && (BYTE_W'(rd_idx_r) + 8'd1 < len_r)) begin
      sum_nxt = sum_r + rd_data;
    end
  end

  assign sts.frame_end = frame_end;
  assign sts.len_ok    = (len_nxt != '0) && (len_nxt <= MAX_B);
  assign sts.chk_done  = rd_vld_r && (BYTE_W'(rd_idx_r) == len_r - 8'd1);
  assign sts.chk_good  = (sum_r == rd_data);
  assign sts.out_free  = !out_vld_r || out_ch.ready;
  assign sts.em_last   = (BYTE_W'(ptr_r) == len_r - 8'd1);

  cfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en && cmd.rx_take),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= HEAD_RST;
      min_r     <= MIN_LEN_RST;
      recv_r    <= 1'b0;
      cnt_r     <= '0;
      len_r     <= '0;
      link_up_r <= 1'b0;
      ptr_r     <= '0;
      rd_vld_r  <= 1'b0;
      sum_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_FRAME_HEAD: head_r <= cfg.data;
          CFG_MIN_LEN:    min_r  <= cfg.data[MIN_LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.rx_take) begin
        recv_r <= recv_nxt;
        cnt_r  <= cnt_nxt;
        len_r  <= len_nxt;
      end
      if (cmd.set_link) begin
        link_up_r <= 1'b1;
      end
      ptr_r    <= ptr_nxt;
      sum_r    <= sum_nxt;
      rd_vld_r <= sum_issue && !cmd.walk_clr;
      if (cmd.em_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_issue) begin
      rd_idx_r <= ptr_r;
    end
    if (cmd.em_load) begin
      out_byte_r <= rd_data;
      out_pos_r  <= POS_W'(ptr_r);
      out_last_r <= sts.em_last;
      out_link_r <= link_up_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.frame_byte    = out_byte_r;
  assign out_ch.byte_position = out_pos_r;
  assign out_ch.last_byte     = out_last_r;
  assign out_ch.link_up       = out_link_r;

  ap_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_FRAME_LEN))
    else $error("byte count beyond frame storage");

  ap_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !recv_r |-> cnt_r == '0)
    else $error("byte count nonzero while not receiving");

  ap_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> BYTE_W'(rd_idx_r) < len_r)
    else $error("checksum read outside frame length");

  ap_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.em_load |-> (!out_vld_r || out_ch.ready) && link_up_r)
    else $error("output item overwritten or emitted before link up");

endmodule

FILE: src/checksummed_frame_receiver.sv
// Checksummed frame receiver.
// in_ch carries one received serial byte per item. Outside a frame, a byte
// equal to the frame_head register opens a frame; the third byte is the frame
// length and aborts the frame when above MAX_FRAME_LEN or below min_frame_len.
// cfg_ch writes frame_head (index 0) and min_frame_len (index 1); it is always
// ready; the user must write it only while no frame is pending, as the block
// does not enforce this. Bytes are taken one per cycle while receiving.
// At frame end the store is read back once to form the 8-bit sum (one store
// read port), then a good frame goes out on out_ch one byte per item, head
// first, with byte_position, last_byte on the checksum byte and the sticky
// link_up flag. Each output byte is a store read, then an output register
// load. in_ch.ready is low from frame end until the last byte is loaded into
// the output register. A bad frame gives no items and in_ch is ready again
// after the sum pass.
// A stalled out_ch holds the current item and pauses the emission walk.
// Reset clears the receive state and link_up and restores the register
// defaults; the frame store has no reset.
module checksummed_frame_receiver import cfr_pkg::*; #(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cfr_in_if.sink     in_ch,
  cfr_out_if.source  out_ch,
  cfr_cfg_if.sink    cfg_ch
);

  cfr_cmd_t cmd;
  cfr_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  cfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfr_dp #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_byte (in_ch.rx_byte),
    .cfg     (cfg_ch),
    .out_ch  (out_ch),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

FILE: tb/sv/cfr_frame_checker.sv
`timescale 1ns / 1ps

module cfr_frame_checker import cfr_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cfr_in_if           in_mon,
  cfr_out_if          out_mon,
  cfr_cfg_if          cfg_mon,
  output int unsigned mismatches,
  output int unsigned frame_bytes_due
);

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic              last_byte;
    logic              link_up;
  } frame_beat_t;

  frame_beat_t       owed_beats[$];
  int unsigned       fail_n = 0;

  logic [BYTE_W-1:0]    head_reg;
  logic [MIN_LEN_W-1:0] min_len_reg;
  logic                 in_frame;
  int unsigned          rx_count;
  logic [BYTE_W-1:0]    rx_store [MAX_LEN];
  logic                 link_seen;

  function automatic void clear_receiver();
    head_reg    = HEAD_RST;
    min_len_reg = MIN_LEN_RST;
    in_frame    = 1'b0;
    rx_count    = 0;
    link_seen   = 1'b0;
    foreach (rx_store[i]) rx_store[i] = '0;
    owed_beats.delete();
  endfunction

  // Advances the receive state by one byte and queues the bytes of a frame
  // that completes with a good sum.
  function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] b);
    int unsigned       len;
    int unsigned       i;
    logic [BYTE_W-1:0] sum;
    frame_beat_t       beat;
    if (b == head_reg && !in_frame) begin
      in_frame    = 1'b1;
      rx_store[0] = b;
      rx_store[2] = BYTE_W'(min_len_reg);
      rx_count    = 1;
    end else if (rx_count == 2) begin
      rx_store[2] = b;
      rx_count    = 3;
      if (b > MAX_LEN || b < min_len_reg) begin
        rx_store[2] = BYTE_W'(min_len_reg);
        in_frame    = 1'b0;
        rx_count    = 0;
      end
    end else if (in_frame && rx_count < MAX_LEN) begin
      rx_store[rx_count] = b;
      rx_count++;
    end

    if ((rx_count >= MAX_LEN || rx_count >= rx_store[2]) && rx_count > min_len_reg) begin
      len = rx_store[2];
      if (len >= 1 && len <= MAX_LEN) begin
        sum = '0;
        for (i = 0; i + 1 < len; i++) sum += rx_store[i];
        if (sum == rx_store[len-1]) begin
          link_seen = 1'b1;
          for (i = 0; i < len; i++) begin
            beat.frame_byte    = rx_store[i];
            beat.byte_position = POS_W'(i);
            beat.last_byte     = (i + 1 == len);
            beat.link_up       = link_seen;
            owed_beats.push_back(beat);
          end
        end
      end
      in_frame = 1'b0;
      rx_count = 0;
    end
  endfunction

  function automatic void check_field(input string field, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_n++;
    end
  endfunction

  always @(posedge clk) begin
    frame_beat_t beat;
    if (!rst_n) begin
      clear_receiver();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfr_cfg_e'(cfg_mon.index))
          CFG_FRAME_HEAD: head_reg = cfg_mon.data;
          CFG_MIN_LEN:    min_len_reg = cfg_mon.data[MIN_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) absorb_rx_byte(in_mon.rx_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (owed_beats.size() == 0) begin
          $error("unexpected frame byte %0d at position %0d", out_mon.frame_byte,
                 out_mon.byte_position);
          fail_n++;
        end else begin
          beat = owed_beats.pop_front();
          check_field("frame_byte", beat.frame_byte, out_mon.frame_byte);
          check_field("byte_position", BYTE_W'(beat.byte_position),
                      BYTE_W'(out_mon.byte_position));
          check_field("last_byte", BYTE_W'(beat.last_byte), BYTE_W'(out_mon.last_byte));
          check_field("link_up", BYTE_W'(beat.link_up), BYTE_W'(out_mon.link_up));
        end
      end
    end
    mismatches      <= fail_n;
    frame_bytes_due <= owed_beats.size();
  end

endmodule

FILE: tb/sv/tb_checksummed_frame_receiver.sv
`timescale 1ns / 1ps

module tb_checksummed_frame_receiver;
  import cfr_pkg::*;

  localparam int unsigned MAX_LEN       = MAX_FRAME_LEN_DEF;
  // sum pass plus a full emission walk
  localparam int unsigned SETTLE_CYCLES = 3 * MAX_LEN + 32;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PHASE_BYTES   = 8;

  typedef enum int {GOOD_FRAME, BAD_SUM_FRAME, BAD_LEN_FRAME} frame_kind_e;

  logic clk;
  logic rst_n;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();
  cfr_cfg_if cfg_ch ();

  int unsigned mismatches;
  int unsigned frame_bytes_due;
  int unsigned gap_pct = 24;
  int unsigned stall_pct = 81;
  int unsigned quiet_cycles = 0;

  logic [BYTE_W-1:0]    head_now = HEAD_RST;
  logic [MIN_LEN_W-1:0] min_now  = MIN_LEN_RST;
  logic [BYTE_W-1:0]    tx_seq[$];

  checksummed_frame_receiver #(.MAX_FRAME_LEN(MAX_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cfr_frame_checker #(.MAX_LEN(MAX_LEN)) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_mon         (cfg_ch),
    .mismatches      (mismatches),
    .frame_bytes_due (frame_bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_seq();
    foreach (tx_seq[i]) send_byte(tx_seq[i]);
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    return BYTE_W'(head_now + $urandom_range(1, 255));
  endfunction

  function automatic void make_frame(input frame_kind_e kind);
    int unsigned       len;
    int unsigned       len_hi;
    int unsigned       span;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] skew;
    tx_seq.delete();
    tx_seq.push_back(head_now);
    tx_seq.push_back(BYTE_W'($urandom));
    if (min_now > MAX_LEN) begin
      // no length passes the window
      tx_seq.push_back(BYTE_W'($urandom));
      return;
    end
    if (kind == BAD_LEN_FRAME) begin
      if ($urandom_range(0, 1) == 0)
        tx_seq.push_back(BYTE_W'($urandom_range(MAX_LEN + 1, 255)));
      else
        tx_seq.push_back(BYTE_W'($urandom_range(0, min_now - 1)));
      return;
    end
    len_hi = (min_now + 5 < MAX_LEN) ? min_now + 5 : MAX_LEN;
    len    = ($urandom_range(0, 9) == 0) ? MAX_LEN : $urandom_range(min_now, len_hi);
    skew   = (kind == BAD_SUM_FRAME) ? BYTE_W'($urandom_range(1, 255)) : '0;
    tx_seq.push_back(BYTE_W'(len));
    if (len == 3) begin
      // the length byte doubles as the checksum
      tx_seq[1] = BYTE_W'(len) - head_now + skew;
    end else begin
      while (tx_seq.size() < len - 1) tx_seq.push_back(BYTE_W'($urandom));
      sum = '0;
      foreach (tx_seq[i]) sum += tx_seq[i];
      tx_seq.push_back(sum + skew);
    end
    // a frame only closes once the count is past min_frame_len
    span = (len > min_now) ? len : min_now + 1;
    while (tx_seq.size() < span) tx_seq.push_back(BYTE_W'($urandom));
  endfunction

  // every sequence sent closes its frame; wait out emission and the sum pass
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (frame_bytes_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] head, input logic [MIN_LEN_W-1:0] min_len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_FRAME_HEAD;
    cfg_ch.data  <= head;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_MIN_LEN;
    cfg_ch.data  <= CFG_DATA_W'(min_len);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    head_now = head;
    min_now  = min_len;
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] head, input logic [MIN_LEN_W-1:0] min_len,
                           input int unsigned gap, input int unsigned stall);
    int unsigned sent;
    int unsigned pick;
    quiesce();
    set_config(head, min_len);
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < PHASE_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        make_frame(pick < 60 ? GOOD_FRAME : (pick < 75 ? BAD_SUM_FRAME : BAD_LEN_FRAME));
        sent += tx_seq.size();
      end else begin
        tx_seq.delete();
        repeat ($urandom_range(1, 3)) tx_seq.push_back(noise_byte());
      end
      send_seq();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_FRAME_HEAD;
    cfg_ch.data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray bytes outside a frame
    tx_seq = {8'h00, 8'hFF};
    send_seq();
    // shortest frame plus the trailing byte it needs to close
    tx_seq = {HEAD_RST, 8'h00, 8'h04, 8'h46, 8'hFF};
    send_seq();
    // bad checksum
    tx_seq = {HEAD_RST, 8'hFF, 8'h05, 8'h12, 8'h00};
    send_seq();
    // length above the store, then below the minimum
    tx_seq = {HEAD_RST, 8'h01, 8'h21, HEAD_RST, 8'h01, 8'h03};
    send_seq();
    // head value inside a frame is plain data
    tx_seq = {HEAD_RST, HEAD_RST, 8'h05, 8'h80, 8'h09};
    send_seq();

    run_phase(8'h00, 7'd3, 24, 81);
    run_phase(8'hFF, 7'd31, 24, 81);
    run_phase(8'h5A, 7'd64, 81, 24);
    run_phase(8'hC3, 7'd45, 81, 24);
    run_phase(8'h7E, 7'd10, 0, 0);
    run_phase(HEAD_RST, MIN_LEN_RST, 0, 0);
    quiesce();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: checksummed_frame_receiver.f
src/cfr_pkg.sv
src/cfr_in_if.sv
src/cfr_out_if.sv
src/cfr_cfg_if.sv
src/cfr_ram.sv
src/cfr_ctrl.sv
src/cfr_dp.sv
src/checksummed_frame_receiver.sv
tb/sv/cfr_frame_checker.sv
tb/sv/tb_checksummed_frame_receiver.sv
